@@ hw/rtl/pscv_pkg.sv @@
`default_nettype none

package pscv_pkg;

  // Channel count limits
  localparam int MAX_CHANNELS = 8;
  localparam int CHAN_LIMIT   = (MAX_CHANNELS < 1) ? 1 : ((MAX_CHANNELS < 8) ? MAX_CHANNELS : 8);

  // Queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Input format codes
  localparam logic [2:0] IN_S_LE  = 3'd0;
  localparam logic [2:0] IN_S_BE  = 3'd1;
  localparam logic [2:0] IN_U_LE  = 3'd2;
  localparam logic [2:0] IN_U_BE  = 3'd3;
  localparam logic [2:0] IN_ALAW  = 3'd4;
  localparam logic [2:0] IN_MULAW = 3'd5;

  // Output format codes
  localparam logic [1:0] OUT_S_LE = 2'd0;
  localparam logic [1:0] OUT_S_BE = 2'd1;
  localparam logic [1:0] OUT_U_LE = 2'd2;
  localparam logic [1:0] OUT_U_BE = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_IN_FORMAT       = 3'd0;
  localparam logic [2:0] REG_IN_BITS         = 3'd1;
  localparam logic [2:0] REG_IN_CHANNELS     = 3'd2;
  localparam logic [2:0] REG_IN_ACTIVE_BITS  = 3'd3;
  localparam logic [2:0] REG_OUT_FORMAT      = 3'd4;
  localparam logic [2:0] REG_OUT_BITS        = 3'd5;
  localparam logic [2:0] REG_OUT_CHANNELS    = 3'd6;
  localparam logic [2:0] REG_OUT_ACTIVE_BITS = 3'd7;

  // Numeric constants
  localparam logic [31:0] UNSIGNED_OFFSET = 32'h7fff_ffff;
  localparam logic [31:0] DITHER_MUL      = 32'h0019_660d;
  localparam logic [31:0] DITHER_INC      = 32'h3c6e_f35f;

  typedef struct packed {
    logic [2:0] in_format;
    logic [5:0] in_bits;
    logic [3:0] in_channels;
    logic [5:0] in_active_bits;
    logic [1:0] out_format;
    logic [5:0] out_bits;
    logic [3:0] out_channels;
    logic [5:0] out_active_bits;
  } cfg_t;

  // One queued item: decoded value and how the back end handles it
  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  pos;
    logic        mix;
    logic        first;
    logic        emit;
    logic        single;
  } item_t;

  function automatic logic [5:0] eff_bits(input logic [5:0] b);
    logic [5:0] r;
    if (b == 6'd0) begin
      r = 6'd1;
    end else if (b > 6'd32) begin
      r = 6'd32;
    end else begin
      r = b;
    end
    return r;
  endfunction

  function automatic logic [3:0] eff_chan(input logic [3:0] c);
    logic [3:0] r;
    if (c == 4'd0) begin
      r = 4'd1;
    end else if (c > 4'(CHAN_LIMIT)) begin
      r = 4'(CHAN_LIMIT);
    end else begin
      r = c;
    end
    return r;
  endfunction

  // Bytes occupied by a sample of 1..32 bits
  function automatic logic [2:0] num_bytes(input logic [5:0] bits);
    logic [5:0] t;
    t = bits + 6'd7;
    return t[5:3];
  endfunction

  // Reverse the low nb bytes, or keep them and clear the rest
  function automatic logic [31:0] byte_order(input logic [31:0] v, input logic [2:0] nb,
                                             input logic swap);
    logic [31:0] r;
    case (nb)
      3'd1: r = {24'h0, v[7:0]};
      3'd2: r = swap ? {16'h0, v[7:0], v[15:8]} : {16'h0, v[15:0]};
      3'd3: r = swap ? {8'h0, v[7:0], v[15:8], v[23:16]} : {8'h0, v[23:0]};
      default: r = swap ? {v[7:0], v[15:8], v[23:16], v[31:24]} : v;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pcm_sample_format_converter_core.sv @@
// Channel   Ports                                   Handshake
// input     raw_sample                              push / full
// result    out_word, out_channel, last             pop / empty
// config    cfg_we, cfg_index, cfg_data             cfg_we, no wait
//
// One input item is taken per cycle while the queue has room; it then passes
// the queue and the mix, dither and output registers. While pop is held, a
// mixed or fanned-out frame gives one word per cycle per output channel, so
// the output port sets the rate (one item per cycle for equal channel counts).
// Synchronous reset clears the queue, stages, channel position and mix sum,
// and loads the seed with the first step of the dither sequence.
// A stalled result port fills the four-entry queue, then raises full.
`default_nettype none

module pcm_sample_format_converter_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [31:0] raw_sample,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      out_word,
  output logic [2:0]       out_channel,
  output logic             last,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [5:0]  cfg_data
);

  pscv_pkg::cfg_t  cfg;
  pscv_pkg::item_t f_item;
  pscv_pkg::item_t b_item;
  logic            f_push;
  logic            q_full;
  logic            q_empty;
  logic            q_pop;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.in_format       <= pscv_pkg::IN_S_LE;
      cfg.in_bits         <= 6'd16;
      cfg.in_channels     <= 4'd2;
      cfg.in_active_bits  <= 6'd16;
      cfg.out_format      <= pscv_pkg::OUT_S_LE;
      cfg.out_bits        <= 6'd16;
      cfg.out_channels    <= 4'd2;
      cfg.out_active_bits <= 6'd16;
    end else if (cfg_we) begin
      case (cfg_index)
        pscv_pkg::REG_IN_FORMAT:       cfg.in_format       <= cfg_data[2:0];
        pscv_pkg::REG_IN_BITS:         cfg.in_bits         <= cfg_data;
        pscv_pkg::REG_IN_CHANNELS:     cfg.in_channels     <= cfg_data[3:0];
        pscv_pkg::REG_IN_ACTIVE_BITS:  cfg.in_active_bits  <= cfg_data;
        pscv_pkg::REG_OUT_FORMAT:      cfg.out_format      <= cfg_data[1:0];
        pscv_pkg::REG_OUT_BITS:        cfg.out_bits        <= cfg_data;
        pscv_pkg::REG_OUT_CHANNELS:    cfg.out_channels    <= cfg_data[3:0];
        pscv_pkg::REG_OUT_ACTIVE_BITS: cfg.out_active_bits <= cfg_data;
        default: ;
      endcase
    end
  end

  assign full = q_full;

  pscv_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .push       (push),
    .raw_sample (raw_sample),
    .q_full     (q_full),
    .q_push     (f_push),
    .q_item     (f_item)
  );

  pscv_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (f_push),
    .wr_item (f_item),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_item (b_item),
    .empty   (q_empty)
  );

  pscv_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_empty     (q_empty),
    .q_item      (b_item),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .out_word    (out_word),
    .out_channel (out_channel),
    .last        (last)
  );

endmodule

`default_nettype wire

@@ hw/rtl/pscv_front.sv @@
`default_nettype none

module pscv_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire pscv_pkg::cfg_t     cfg,
  input  wire logic               push,
  input  wire logic [31:0]        raw_sample,
  input  wire logic               q_full,
  output logic                    q_push,
  output pscv_pkg::item_t         q_item
);

  logic [2:0]  chpos;
  logic [2:0]  chpos_next;
  logic        accept;
  logic [3:0]  nin;
  logic [3:0]  nout;
  logic [3:0]  nin_m1;
  logic [2:0]  pos;
  logic        lastch;
  logic [31:0] decoded;

  assign accept = push && !q_full;

  // Resolve the channel position of this item
  always_comb begin
    nin    = pscv_pkg::eff_chan(cfg.in_channels);
    nout   = pscv_pkg::eff_chan(cfg.out_channels);
    nin_m1 = nin - 4'd1;
    if ({1'b0, chpos} > nin_m1) begin
      pos = nin_m1[2:0];
    end else begin
      pos = chpos;
    end
    lastch     = ({1'b0, pos} == nin_m1);
    chpos_next = lastch ? 3'd0 : pos + 3'd1;
  end

  // Decode the raw word into a left-aligned signed value
  always_comb begin
    logic [7:0]  a;
    logic [7:0]  u;
    logic [7:0]  t8;
    logic [2:0]  seg;
    logic [15:0] mag;
    logic [15:0] tt;
    logic [5:0]  bits;
    logic [5:0]  sh;
    logic [31:0] v;
    a   = raw_sample[7:0] ^ 8'h55;
    u   = ~raw_sample[7:0];
    t8  = {a[3:0], 4'h0};
    seg = a[6:4];
    mag = 16'h0;
    tt  = 16'h0;
    bits = pscv_pkg::eff_bits(cfg.in_bits);
    sh   = 6'd32 - bits;
    v    = 32'h0;
    case (cfg.in_format)
      pscv_pkg::IN_ALAW: begin
        if (seg == 3'd0) begin
          mag = 16'(t8) + 16'd8;
        end else begin
          mag = (16'(t8) + 16'h108) << ((seg > 3'd1) ? seg - 3'd1 : 3'd0);
        end
        decoded = a[7] ? {mag, 16'h0} : 32'd0 - {mag, 16'h0};
      end
      pscv_pkg::IN_MULAW: begin
        tt  = (16'({u[3:0], 3'b000}) + 16'h84) << u[6:4];
        mag = tt - 16'h84;
        decoded = u[7] ? 32'd0 - {mag, 16'h0} : {mag, 16'h0};
      end
      default: begin
        v = pscv_pkg::byte_order(raw_sample, pscv_pkg::num_bytes(bits),
                                 (cfg.in_format == pscv_pkg::IN_S_BE) ||
                                 (cfg.in_format == pscv_pkg::IN_U_BE));
        v = v << sh[4:0];
        if ((cfg.in_format == pscv_pkg::IN_U_LE) || (cfg.in_format == pscv_pkg::IN_U_BE)) begin
          v = v - pscv_pkg::UNSIGNED_OFFSET;
        end
        decoded = v;
      end
    endcase
  end

  // Classify the item for the back end
  always_comb begin
    q_item.value  = decoded;
    q_item.pos    = pos;
    q_item.first  = (pos == 3'd0);
    q_item.mix    = 1'b0;
    q_item.emit   = 1'b0;
    q_item.single = 1'b0;
    q_push        = 1'b0;
    if (nin == nout) begin
      q_item.emit   = 1'b1;
      q_item.single = 1'b1;
      q_push        = accept;
    end else if (nin > nout) begin
      q_item.mix  = 1'b1;
      q_item.emit = lastch;
      q_push      = accept;
    end else begin
      q_item.emit = 1'b1;
      q_push      = accept && (pos == 3'd0);
    end
  end

  // Advance the channel position on every accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      chpos <= 3'd0;
    end else if (accept) begin
      chpos <= chpos_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/pscv_fifo.sv @@
`default_nettype none

module pscv_fifo (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr_en,
  input  wire pscv_pkg::item_t wr_item,
  output logic                 full,
  input  wire logic            rd_en,
  output pscv_pkg::item_t      rd_item,
  output logic                 empty
);

  pscv_pkg::item_t                  mem [pscv_pkg::FIFO_DEPTH];
  logic [pscv_pkg::FIFO_AW-1:0]     wr_ptr;
  logic [pscv_pkg::FIFO_AW-1:0]     rd_ptr;
  logic [pscv_pkg::FIFO_AW:0]       count;
  logic                             do_wr;
  logic                             do_rd;

  assign full    = (count == (pscv_pkg::FIFO_AW + 1)'(pscv_pkg::FIFO_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_item = mem[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  // Move pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/pscv_back.sv @@
`default_nettype none

module pscv_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire pscv_pkg::cfg_t  cfg,
  input  wire logic            q_empty,
  input  wire pscv_pkg::item_t q_item,
  output logic                 q_pop,
  output logic                 empty,
  input  wire logic            pop,
  output logic [31:0]          out_word,
  output logic [2:0]           out_channel,
  output logic                 last
);

  // Mix stage
  logic        mix_valid;
  logic [31:0] mix_val;
  logic [2:0]  mix_pos;
  logic        mix_single;
  logic        mix_mixed;
  logic [31:0] mix_sum;
  // Dither stage
  logic        dit_valid;
  logic [31:0] dit_val;
  logic [2:0]  dit_pos;
  logic        dit_single;
  logic [31:0] seed;
  // Output register
  logic        out_valid;
  logic [31:0] word;
  logic [2:0]  opos;
  logic        osingle;
  logic [2:0]  kidx;

  logic        mix_ready;
  logic        dit_ready;
  logic        out_ready;
  logic        out_last;
  logic [3:0]  nout;
  logic [3:0]  nout_m1;
  logic [31:0] mixed;
  logic        dither_on;
  logic [31:0] dithered;
  logic [31:0] seed_next;
  logic [31:0] encoded;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    logic [31:0] r;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      r = s[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  assign nout     = pscv_pkg::eff_chan(cfg.out_channels);
  assign nout_m1  = nout - 4'd1;
  assign out_last = osingle || ({1'b0, kidx} == nout_m1);

  assign out_ready = !out_valid || (pop && out_last);
  assign dit_ready = !dit_valid || out_ready;
  assign mix_ready = !mix_valid || dit_ready;
  assign q_pop     = !q_empty && mix_ready;

  // Load or accumulate the mix sum
  always_comb begin
    if (q_item.mix && !q_item.first) begin
      mixed = sat_add(mix_sum, q_item.value);
    end else begin
      mixed = q_item.value;
    end
  end

  // Add dither from the current seed when dithering is on
  always_comb begin
    dither_on = (cfg.in_active_bits < 6'd32) && (cfg.out_active_bits < cfg.in_active_bits);
    seed_next = 32'(seed * pscv_pkg::DITHER_MUL) + pscv_pkg::DITHER_INC;
    if (dither_on) begin
      dithered = sat_add(mix_val, unsigned'($signed(seed) >>> cfg.in_active_bits[4:0]));
    end else begin
      dithered = mix_val;
    end
  end

  // Encode into the output format
  always_comb begin
    logic [5:0]  bits;
    logic [5:0]  sh;
    logic [31:0] v;
    bits = pscv_pkg::eff_bits(cfg.out_bits);
    sh   = 6'd32 - bits;
    if ((cfg.out_format == pscv_pkg::OUT_U_LE) || (cfg.out_format == pscv_pkg::OUT_U_BE)) begin
      v = (dit_val + pscv_pkg::UNSIGNED_OFFSET) >> sh[4:0];
    end else begin
      v = unsigned'($signed(dit_val) >>> sh[4:0]);
    end
    encoded = pscv_pkg::byte_order(v, pscv_pkg::num_bytes(bits),
                                   (cfg.out_format == pscv_pkg::OUT_S_BE) ||
                                   (cfg.out_format == pscv_pkg::OUT_U_BE));
  end

  // Mix stage: hold emitting items, drop the rest after updating the sum
  always_ff @(posedge clk) begin
    if (rst) begin
      mix_valid <= 1'b0;
      mix_sum   <= 32'h0;
    end else begin
      if (mix_ready) begin
        mix_valid <= q_pop && q_item.emit;
      end
      // Keep the dithered frame sum once the last channel leaves this stage
      if (mix_ready && q_pop && q_item.mix) begin
        mix_sum <= mixed;
      end else if (dit_ready && mix_valid && mix_mixed) begin
        mix_sum <= dithered;
      end
    end
    if (mix_ready && q_pop) begin
      mix_val    <= mixed;
      mix_pos    <= q_item.pos;
      mix_single <= q_item.single;
      mix_mixed  <= q_item.mix;
    end
  end

  // Dither stage: advance the seed once per dithered value
  always_ff @(posedge clk) begin
    if (rst) begin
      dit_valid <= 1'b0;
      seed      <= pscv_pkg::DITHER_INC;
    end else if (dit_ready) begin
      dit_valid <= mix_valid;
      if (mix_valid && dither_on) begin
        seed <= seed_next;
      end
    end
    if (dit_ready && mix_valid) begin
      dit_val    <= dithered;
      dit_pos    <= mix_pos;
      dit_single <= mix_single;
    end
  end

  // Output register: fan out one word per output channel unless the item is single
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      kidx      <= 3'd0;
    end else if (out_ready) begin
      out_valid <= dit_valid;
      kidx      <= 3'd0;
    end else if (pop) begin
      kidx <= kidx + 3'd1;
    end
    if (out_ready && dit_valid) begin
      word    <= encoded;
      opos    <= dit_pos;
      osingle <= dit_single;
    end
  end

  assign empty       = !out_valid;
  assign out_word    = word;
  assign out_channel = osingle ? opos : kidx;
  assign last        = out_last;

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import pscv_pkg::*;

  // Input format codes with no meaning of their own; they decode as signed LE
  localparam logic [2:0] IN_SPARE6 = 3'd6;
  localparam logic [2:0] IN_SPARE7 = 3'd7;

  localparam int SETTLE_CYCLES = 10;
  localparam int END_CYCLES    = 20;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int RANDOM_ITEMS  = 195;
  localparam int PAUSE_AT      = 70;
  localparam int QUIET_FROM    = 165;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  chan;
    logic        fin;
  } conv_word_t;

  // Tracks converter state and the output words still owed by the block
  class pcm_conv_tracker;
    cfg_t        cfg = '{in_format: IN_S_LE, in_bits: 6'd16, in_channels: 4'd2,
                         in_active_bits: 6'd16, out_format: OUT_S_LE, out_bits: 6'd16,
                         out_channels: 4'd2, out_active_bits: 6'd16};
    logic [31:0] seed = '0;
    logic [2:0]  chan_pos = '0;
    logic [31:0] mix = '0;
    conv_word_t  awaited_words[$];
    int          mismatches = 0;

    function void set_reg(input logic [2:0] idx, input logic [5:0] d);
      case (idx)
        REG_IN_FORMAT:       cfg.in_format = d[2:0];
        REG_IN_BITS:         cfg.in_bits = d;
        REG_IN_CHANNELS:     cfg.in_channels = d[3:0];
        REG_IN_ACTIVE_BITS:  cfg.in_active_bits = d;
        REG_OUT_FORMAT:      cfg.out_format = d[1:0];
        REG_OUT_BITS:        cfg.out_bits = d;
        REG_OUT_CHANNELS:    cfg.out_channels = d[3:0];
        REG_OUT_ACTIVE_BITS: cfg.out_active_bits = d;
        default: ;
      endcase
    endfunction

    function int unsigned clamp_bits(input logic [5:0] b);
      if (b == 0) return 1;
      return (b > 32) ? 32 : b;
    endfunction

    function int unsigned clamp_chan(input logic [3:0] c);
      if (c == 0) return 1;
      return (c > CHAN_LIMIT) ? CHAN_LIMIT : c;
    endfunction

    function logic [31:0] low_bytes(input int unsigned nb);
      return (nb >= 4) ? 32'hffff_ffff : ((32'd1 << (8 * nb)) - 32'd1);
    endfunction

    function logic [31:0] swap_bytes(input logic [31:0] v, input int unsigned nb);
      logic [31:0] r;
      int unsigned i;
      r = '0;
      for (i = 0; i < nb; i++) begin
        r |= ((v >> (8 * i)) & 32'hff) << (8 * (nb - 1 - i));
      end
      return r;
    endfunction

    function logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      longint s;
      s = longint'($signed(a)) + longint'($signed(b));
      if (s > 64'sh7fff_ffff) s = 64'sh7fff_ffff;
      if (s < -64'sh8000_0000) s = -64'sh8000_0000;
      return 32'(s);
    endfunction

    // Turn a raw word into a left-aligned signed 32-bit value
    function logic [31:0] decode_sample(input logic [31:0] raw);
      logic [31:0] t;
      logic [31:0] v;
      logic [7:0]  a;
      int unsigned seg;
      int unsigned bits;
      int unsigned nb;
      if (cfg.in_format == IN_ALAW) begin
        a = raw[7:0] ^ 8'h55;
        t = {24'h0, a[3:0], 4'h0};
        seg = a[6:4];
        if (seg == 0) begin
          t = t + 32'd8;
        end else begin
          t = (t + 32'h108) << ((seg > 1) ? seg - 1 : 0);
        end
        if (!a[7]) t = 32'd0 - t;
        return t << 16;
      end
      if (cfg.in_format == IN_MULAW) begin
        a = ~raw[7:0];
        t = ({24'h0, 1'b0, a[3:0], 3'h0} + 32'h84) << a[6:4];
        t = a[7] ? (32'h84 - t) : (t - 32'h84);
        return t << 16;
      end
      bits = clamp_bits(cfg.in_bits);
      nb = (bits + 7) / 8;
      if (cfg.in_format == IN_S_BE || cfg.in_format == IN_U_BE) begin
        v = swap_bytes(raw, nb);
      end else begin
        v = raw & low_bytes(nb);
      end
      v = v << (32 - bits);
      if (cfg.in_format == IN_U_LE || cfg.in_format == IN_U_BE) v = v - UNSIGNED_OFFSET;
      return v;
    endfunction

    function logic [31:0] encode_sample(input logic [31:0] x);
      logic [31:0] v;
      int unsigned bits;
      int unsigned nb;
      int unsigned s;
      bits = clamp_bits(cfg.out_bits);
      nb = (bits + 7) / 8;
      s = 32 - bits;
      if (cfg.out_format == OUT_U_LE || cfg.out_format == OUT_U_BE) begin
        v = (x + UNSIGNED_OFFSET) >> s;
      end else begin
        v = $signed(x) >>> s;
      end
      if (cfg.out_format == OUT_S_BE || cfg.out_format == OUT_U_BE) return swap_bytes(v, nb);
      return v & low_bytes(nb);
    endfunction

    // Advance the LCG and add its scaled value, only when output is narrower and input active bits are under 32
    function logic [31:0] dither(input logic [31:0] x);
      logic [31:0] noise;
      if (cfg.in_active_bits >= 32 || cfg.out_active_bits >= cfg.in_active_bits) return x;
      seed = seed * DITHER_MUL + DITHER_INC;
      noise = $signed(seed) >>> cfg.in_active_bits;
      return sat_add(x, noise);
    endfunction

    function void fan_out(input logic [31:0] word, input int unsigned nout);
      int unsigned k;
      for (k = 0; k < nout; k++) begin
        awaited_words.push_back('{word: word, chan: 3'(k), fin: (k + 1 == nout)});
      end
    endfunction

    // Predict the words caused by one accepted sample
    function void note_sample(input logic [31:0] raw);
      int unsigned nin;
      int unsigned nout;
      int unsigned pos;
      logic [31:0] x;
      logic        lastch;
      nin = clamp_chan(cfg.in_channels);
      nout = clamp_chan(cfg.out_channels);
      pos = chan_pos;
      if (pos > nin - 1) pos = nin - 1;
      lastch = (pos == nin - 1);
      x = decode_sample(raw);
      if (nin == nout) begin
        awaited_words.push_back('{word: encode_sample(dither(x)), chan: 3'(pos), fin: 1'b1});
      end else if (nin > nout) begin
        mix = (pos == 0) ? x : sat_add(mix, x);
        if (lastch) begin
          mix = dither(mix);
          fan_out(encode_sample(mix), nout);
        end
      end else if (pos == 0) begin
        fan_out(encode_sample(dither(x)), nout);
      end
      chan_pos = lastch ? 3'd0 : 3'(pos + 1);
    endfunction

    function void check_word(input logic [31:0] word, input logic [2:0] chan, input logic fin);
      conv_word_t exp_w;
      if (awaited_words.size() == 0) begin
        $error("unexpected output word %h on channel %0d", word, chan);
        mismatches++;
        return;
      end
      exp_w = awaited_words.pop_front();
      if (word !== exp_w.word) begin
        $error("out_word: expected %h, actual %h", exp_w.word, word);
        mismatches++;
      end
      if (chan !== exp_w.chan) begin
        $error("out_channel: expected %0d, actual %0d", exp_w.chan, chan);
        mismatches++;
      end
      if (fin !== exp_w.fin) begin
        $error("last: expected %0d, actual %0d", exp_w.fin, fin);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [31:0] raw_sample = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] out_word;
  logic [2:0]  out_channel;
  logic        last;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = REG_IN_FORMAT;
  logic [5:0]  cfg_data = '0;

  pcm_conv_tracker sb;
  logic            quiet = 1'b0;
  int              pop_hold = 0;
  int              cycles = 0;
  int              random_sent;
  int              n;

  pcm_sample_format_converter_core DUT (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .raw_sample(raw_sample),
    .empty(empty),
    .pop(pop),
    .out_word(out_word),
    .out_channel(out_channel),
    .last(last),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Stall the result side in random bursts
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (pop_hold > 0) begin
      pop_hold <= pop_hold - 1;
      pop <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      pop_hold <= $urandom_range(0, 10);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // Record accepted samples and check accepted words
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) sb.note_sample(raw_sample);
      if (pop && !empty) sb.check_word(out_word, out_channel, last);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Present one sample and hold it until the block takes it
  task automatic send_item(input logic [31:0] raw);
    push <= 1'b1;
    raw_sample <= raw;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic feed(input logic [31:0] raw);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    send_item(raw);
  endtask

  // Drop push, wait for every owed word, then let the pipeline empty
  task automatic wait_for_results();
    push <= 1'b0;
    while (sb.awaited_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [5:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    sb.set_reg(idx, d);
    @(negedge clk);
  endtask

  task automatic load_config(input cfg_t c);
    write_reg(REG_IN_FORMAT, 6'(c.in_format));
    write_reg(REG_IN_BITS, c.in_bits);
    write_reg(REG_IN_CHANNELS, 6'(c.in_channels));
    write_reg(REG_IN_ACTIVE_BITS, c.in_active_bits);
    write_reg(REG_OUT_FORMAT, 6'(c.out_format));
    write_reg(REG_OUT_BITS, c.out_bits);
    write_reg(REG_OUT_CHANNELS, 6'(c.out_channels));
    write_reg(REG_OUT_ACTIVE_BITS, c.out_active_bits);
    cfg_we <= 1'b0;
  endtask

  // Mostly legal bit counts, now and then zero or past 32
  function automatic logic [5:0] pick_bits();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 6'd0;
    if (r == 1) return 6'($urandom_range(33, 63));
    if (r < 6) return 6'(8 * $urandom_range(1, 4));
    return 6'($urandom_range(1, 32));
  endfunction

  function automatic logic [3:0] pick_chan();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 4'd0;
    if (r == 1) return 4'($urandom_range(9, 15));
    return 4'($urandom_range(1, 8));
  endfunction

  function automatic cfg_t random_config();
    cfg_t        c;
    int unsigned r;
    r = $urandom_range(0, 13);
    c.in_format = (r < 12) ? 3'(r / 2) : ((r == 12) ? IN_SPARE6 : IN_SPARE7);
    c.in_bits = pick_bits();
    c.in_channels = pick_chan();
    c.in_active_bits = pick_bits();
    c.out_format = 2'($urandom_range(0, 3));
    c.out_bits = pick_bits();
    c.out_channels = (r % 3 == 0) ? c.in_channels : pick_chan();
    // Favor a narrower output so the dither path stays busy
    if ($urandom_range(0, 1) == 0 && c.in_active_bits > 1 && c.in_active_bits < 33) begin
      c.out_active_bits = 6'($urandom_range(0, c.in_active_bits - 1));
    end else begin
      c.out_active_bits = pick_bits();
    end
    return c;
  endfunction

  function automatic logic [31:0] random_raw();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    sb = new;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: 16-bit signed LE, two channels in and out
    send_item(32'h0000_0000);
    send_item(32'hffff_ffff);
    send_item(32'h0000_7fff);
    send_item(32'h0000_8000);

    // A-law, one channel, full 32-bit signed BE output, no dither
    wait_for_results();
    load_config('{in_format: IN_ALAW, in_bits: 6'd5, in_channels: 4'd1,
                  in_active_bits: 6'd32, out_format: OUT_S_BE, out_bits: 6'd32,
                  out_channels: 4'd1, out_active_bits: 6'd32});
    send_item(32'h0000_0055);
    send_item(32'h0000_00d5);
    send_item(32'hffff_ff00);
    send_item(32'h0000_00ff);

    // mu-law to 8-bit unsigned with dither
    wait_for_results();
    load_config('{in_format: IN_MULAW, in_bits: 6'd0, in_channels: 4'd1,
                  in_active_bits: 6'd31, out_format: OUT_U_LE, out_bits: 6'd8,
                  out_channels: 4'd1, out_active_bits: 6'd1});
    send_item(32'h0000_0000);
    send_item(32'h0000_00ff);
    send_item(32'h0000_007f);
    send_item(32'h1234_5680);

    // Four unsigned BE channels mixed to one; saturate high, then low
    wait_for_results();
    load_config('{in_format: IN_U_BE, in_bits: 6'd32, in_channels: 4'd4,
                  in_active_bits: 6'd24, out_format: OUT_S_LE, out_bits: 6'd32,
                  out_channels: 4'd1, out_active_bits: 6'd8});
    repeat (4) send_item(32'hfeff_ffff);
    repeat (4) send_item(32'hffff_ffff);

    // Zero and oversized counts, spare format: one channel fanned to eight
    wait_for_results();
    load_config('{in_format: IN_SPARE6, in_bits: 6'd0, in_channels: 4'd0,
                  in_active_bits: 6'd0, out_format: OUT_U_BE, out_bits: 6'd63,
                  out_channels: 4'd15, out_active_bits: 6'd63});
    send_item(32'h0000_0001);
    send_item(32'h0000_0000);

    // Other spare format, three channels mixed to two with dither
    wait_for_results();
    load_config('{in_format: IN_SPARE7, in_bits: 6'd24, in_channels: 4'd3,
                  in_active_bits: 6'd20, out_format: OUT_S_BE, out_bits: 6'd24,
                  out_channels: 4'd2, out_active_bits: 6'd12});
    send_item(32'h00ab_cdef);
    send_item(32'h0080_0000);
    send_item(32'h007f_ffff);

    // Random settings, each for a short run of random samples
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      wait_for_results();
      load_config(random_config());
      n = $urandom_range(4, 24);
      repeat (n) begin
        if (random_sent == PAUSE_AT) wait_for_results();
        quiet = (random_sent >= QUIET_FROM);
        feed(random_raw());
        random_sent++;
      end
    end

    wait_for_results();
    repeat (END_CYCLES) @(negedge clk);
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
